>>> design/position_average_cost_tracker_macros.svh
// ----------------------------------------------------------------------------
// position average cost tracker assertion macros
// shared property forms for the tracker checks
// ----------------------------------------------------------------------------
`ifndef POSITION_AVERAGE_COST_TRACKER_MACROS_SVH
`define POSITION_AVERAGE_COST_TRACKER_MACROS_SVH

// same-cycle implication, disabled in reset
`define PACT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PACT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pact_pkg.sv
// ----------------------------------------------------------------------------
// pact_pkg
// constants and status codes of the position average cost tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pact_pkg;

    localparam int DEF_SYMBOL_SLOTS  = 256;
    localparam int DEF_POSITION_BITS = 48;

    localparam int SLOT_BITS  = 8;
    localparam int PRICE_BITS = 31;
    localparam int QTY_BITS   = 32;
    localparam int ACC_BITS   = 64;
    localparam int IN_BITS    = 72;

    typedef enum logic [1:0] {
        ST_APPLIED  = 2'd0,
        ST_REJECTED = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

endpackage

>>> design/position_average_cost_tracker.sv
// result path: a rejected or dropped fill passes reduce, load, eval, write and out;
//   an opposing fill adds the multiplier steps, an adding fill adds the multiplier
//   steps and 31 divide steps, plus one reduction subtract per multiple of
//   SYMBOL_SLOTS in the slot and any wait on a held result word
// throughput: one fill at a time, the next is taken after the result is loaded
// reset: async active low, then a table clearing pass during which no fill is accepted
// ----------------------------------------------------------------------------
// position_average_cost_tracker
// per-symbol position, average entry price and realized p&l in one table
// memory, read-modify-write with a shared multiplier and a serial divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "position_average_cost_tracker_macros.svh"

module position_average_cost_tracker #(
    parameter int SYMBOL_SLOTS  = pact_pkg::DEF_SYMBOL_SLOTS,
    parameter int POSITION_BITS = pact_pkg::DEF_POSITION_BITS,
    parameter int OUT_BITS      = ((POSITION_BITS + 31 + 6 * 64 + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // symbol_slot, fill_price, fill_quantity, zero pad
    input  logic [pact_pkg::IN_BITS-1:0]  s_tdata,
    // is_sell
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // net_position, entry_price, realized_profit, symbol_bought, symbol_sold,
    // all_position, all_bought, all_sold, zero pad
    output logic [OUT_BITS-1:0]           m_tdata,
    // status
    output logic [1:0]                    m_tuser
);
    import pact_pkg::*;

    localparam int PB     = POSITION_BITS;
    localparam int SLOT_W = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
    localparam int RED_W  = (SLOT_W > SLOT_BITS) ? SLOT_W : SLOT_BITS;
    localparam int NUM_W  = PB + 32;
    localparam int PAD_W  = OUT_BITS - (PB + PRICE_BITS + 6 * ACC_BITS);

    typedef struct packed {
        logic signed [PB-1:0]   pos;
        logic [PRICE_BITS-1:0]  avg;
        logic [ACC_BITS-1:0]    profit;
        logic [ACC_BITS-1:0]    bought;
        logic [ACC_BITS-1:0]    sold;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_REDUCE, S_LOAD, S_EVAL, S_MUL, S_DIV, S_WRITE, S_OUT
    } state_t;

    // table memory, one entry per symbol slot
    entry_t mem [SYMBOL_SLOTS];
    entry_t rd_data_reg;

    state_t                 state_reg;
    logic [SLOT_W-1:0]      clr_reg;
    logic [RED_W-1:0]       slot_reg;
    logic                   sell_reg;
    logic [PRICE_BITS-1:0]  price_reg;
    logic [QTY_BITS-1:0]    qty_reg;
    entry_t                 new_reg;
    status_t                status_reg;
    logic                   same_reg;
    logic [PB-1:0]          cur_reg;
    logic [PB-1:0]          dvs_reg;
    logic signed [32:0]     diff_reg;
    logic [QTY_BITS-1:0]    closed_reg;
    logic [1:0]             step_reg;
    logic signed [65:0]     prod_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [PB:0]            rem_reg;
    logic [PRICE_BITS-1:0]  quo_reg;
    logic [4:0]             cnt_reg;
    logic [ACC_BITS-1:0]    sum_pos_reg;
    logic [ACC_BITS-1:0]    sum_bought_reg;
    logic [ACC_BITS-1:0]    sum_sold_reg;
    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    out_data_reg;
    logic [1:0]             out_user_reg;

    logic                   slot_big;
    logic [SLOT_W-1:0]      idx;
    logic                   rd_en;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    entry_t                 wr_next;
    entry_t                 eval_next;
    logic                   out_load;

    logic signed [PB:0]     npos_next;
    logic                   ovf_next;
    logic [PB-1:0]          cur_next;
    logic                   same_next;
    logic signed [32:0]     mul_a;
    logic signed [32:0]     mul_b;
    logic [NUM_W-1:0]       num_next;
    logic [PB:0]            r2_next;
    logic                   ge_next;
    logic [PB:0]            rem_next;
    logic [PRICE_BITS-1:0]  quo_next;
    logic                   npos_zero;
    logic                   npos_long;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // result register loads when empty or being drained this cycle
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // slot reduction modulo the table depth, one subtract a cycle
    assign slot_big = ({{(32 - RED_W){1'b0}}, slot_reg} >= 32'(SYMBOL_SLOTS));
    assign idx      = slot_reg[SLOT_W-1:0];
    assign rd_en    = (state_reg == S_REDUCE) && !slot_big;
    assign wr_en    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign wr_addr  = (state_reg == S_CLEAR) ? clr_reg : idx;

    always_comb
    begin
        wr_next = new_reg;
        if (state_reg == S_CLEAR)
        begin
            wr_next = '0;
        end
        else if (same_reg && (status_reg == ST_APPLIED))
        begin
            wr_next.avg = quo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_next;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    // fill evaluation against the entry just read
    always_comb
    begin
        if (sell_reg)
        begin
            npos_next = {rd_data_reg.pos[PB-1], rd_data_reg.pos}
                      - $signed({{(PB + 1 - QTY_BITS){1'b0}}, qty_reg});
        end
        else
        begin
            npos_next = {rd_data_reg.pos[PB-1], rd_data_reg.pos}
                      + $signed({{(PB + 1 - QTY_BITS){1'b0}}, qty_reg});
        end
        ovf_next  = (npos_next[PB] != npos_next[PB-1]);
        cur_next  = rd_data_reg.pos[PB-1] ? (PB'(0) - PB'(rd_data_reg.pos))
                                          : PB'(rd_data_reg.pos);
        same_next = (rd_data_reg.pos == '0)
                 || ((!rd_data_reg.pos[PB-1]) == (!sell_reg));
        npos_zero = (npos_next == '0);
        npos_long = !npos_next[PB] && !npos_zero;

        // updated entry for an applied fill, unchanged otherwise
        eval_next = rd_data_reg;
        if ((price_reg != '0) && (qty_reg != '0) && !ovf_next)
        begin
            eval_next.pos = npos_next[PB-1:0];
            if (sell_reg)
            begin
                eval_next.sold = rd_data_reg.sold + ACC_BITS'(qty_reg);
            end
            else
            begin
                eval_next.bought = rd_data_reg.bought + ACC_BITS'(qty_reg);
            end
            // opposing fill: cleared when flat, fill price on flip
            if (!same_next)
            begin
                if (npos_zero)
                begin
                    eval_next.avg = '0;
                end
                else if (npos_long == !sell_reg)
                begin
                    eval_next.avg = price_reg;
                end
            end
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = diff_reg;
        mul_b = $signed({1'b0, closed_reg});
        if (same_reg)
        begin
            case (step_reg)
                2'd0:
                begin
                    mul_a = $signed({1'b0, cur_reg[31:0]});
                    mul_b = $signed({2'b0, new_reg.avg});
                end
                2'd1:
                begin
                    mul_a = $signed({{(65 - PB){1'b0}}, cur_reg[PB-1:32]});
                    mul_b = $signed({2'b0, new_reg.avg});
                end
                default:
                begin
                    mul_a = $signed({2'b0, price_reg});
                    mul_b = $signed({1'b0, qty_reg});
                end
            endcase
        end
    end

    // weighted sum accumulation and divider step
    always_comb
    begin
        case (step_reg)
            2'd1:    num_next = NUM_W'(prod_reg[63:0]);
            2'd2:    num_next = num_reg + (NUM_W'(prod_reg[63:0]) << 32);
            default: num_next = num_reg + NUM_W'(prod_reg[63:0]);
        endcase
        r2_next  = {rem_reg[PB-1:0], quo_reg[PRICE_BITS-1]};
        ge_next  = (r2_next >= {1'b0, dvs_reg});
        rem_next = ge_next ? (r2_next - {1'b0, dvs_reg}) : r2_next;
        quo_next = {quo_reg[PRICE_BITS-2:0], ge_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            slot_reg       <= '0;
            sell_reg       <= 1'b0;
            price_reg      <= '0;
            qty_reg        <= '0;
            new_reg        <= '0;
            status_reg     <= ST_APPLIED;
            same_reg       <= 1'b0;
            cur_reg        <= '0;
            dvs_reg        <= '0;
            diff_reg       <= '0;
            closed_reg     <= '0;
            step_reg       <= '0;
            prod_reg       <= '0;
            num_reg        <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            cnt_reg        <= '0;
            sum_pos_reg    <= '0;
            sum_bought_reg <= '0;
            sum_sold_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_user_reg   <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + SLOT_W'(1);
                    if (clr_reg == SLOT_W'(SYMBOL_SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        slot_reg  <= RED_W'(s_tdata[7:0]);
                        price_reg <= s_tdata[38:8];
                        qty_reg   <= s_tdata[70:39];
                        sell_reg  <= s_tuser;
                        state_reg <= S_REDUCE;
                    end
                end
                S_REDUCE:
                begin
                    if (slot_big)
                    begin
                        slot_reg <= slot_reg - RED_W'(SYMBOL_SLOTS);
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    new_reg  <= eval_next;
                    cur_reg  <= cur_next;
                    same_reg <= same_next;
                    step_reg <= '0;
                    if ((price_reg == '0) || (qty_reg == '0))
                    begin
                        status_reg <= ST_REJECTED;
                        state_reg  <= S_WRITE;
                    end
                    else if (ovf_next)
                    begin
                        status_reg <= ST_OVERFLOW;
                        state_reg  <= S_WRITE;
                    end
                    else
                    begin
                        status_reg <= ST_APPLIED;
                        // magnitude of the new position, fits since it adds
                        dvs_reg    <= cur_next + PB'(qty_reg);
                        closed_reg <= (cur_next < PB'(qty_reg)) ? cur_next[31:0] : qty_reg;
                        if (!rd_data_reg.pos[PB-1])
                        begin
                            diff_reg <= $signed({2'b0, price_reg})
                                      - $signed({2'b0, rd_data_reg.avg});
                        end
                        else
                        begin
                            diff_reg <= $signed({2'b0, rd_data_reg.avg})
                                      - $signed({2'b0, price_reg});
                        end
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= mul_a * mul_b;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg != 2'd0)
                    begin
                        num_reg <= num_next;
                    end
                    if (!same_reg && (step_reg == 2'd1))
                    begin
                        new_reg.profit <= new_reg.profit + prod_reg[63:0];
                        state_reg      <= S_WRITE;
                    end
                    else if (step_reg == 2'd3)
                    begin
                        // quotient fits 31 bits, so the top part is below the divisor
                        rem_reg   <= num_next[NUM_W-1:PRICE_BITS];
                        quo_reg   <= num_next[PRICE_BITS-1:0];
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(PRICE_BITS - 1))
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    new_reg.avg <= wr_next.avg;
                    if (status_reg == ST_APPLIED)
                    begin
                        if (sell_reg)
                        begin
                            sum_sold_reg <= sum_sold_reg + ACC_BITS'(qty_reg);
                            sum_pos_reg  <= sum_pos_reg - ACC_BITS'(qty_reg);
                        end
                        else
                        begin
                            sum_bought_reg <= sum_bought_reg + ACC_BITS'(qty_reg);
                            sum_pos_reg    <= sum_pos_reg + ACC_BITS'(qty_reg);
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // waits only while an earlier word is still held
                    if (out_load)
                    begin
                        out_user_reg  <= status_reg;
                        out_data_reg  <= {{PAD_W{1'b0}}, sum_sold_reg, sum_bought_reg,
                                          sum_pos_reg, new_reg.sold, new_reg.bought,
                                          new_reg.profit, new_reg.avg, new_reg.pos};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a held result word is never overwritten
    `PACT_ASSERT_NEXT(a_out_hold, (state_reg == S_OUT) && out_valid_reg && !m_tready, state_reg == S_OUT, "result overwritten while stalled")
    // divisor of the average is never zero
    `PACT_ASSERT_NOW(a_div_nonzero, state_reg == S_DIV, dvs_reg != '0, "zero divisor")
    // status code stays within the defined codes
    `PACT_ASSERT_NOW(a_status_code, m_tvalid, m_tuser != 2'd3, "undefined status code")

endmodule
